// ===== hdl/skl_pkg.sv =====
`default_nettype none

package skl_pkg;

    localparam int DEF_CAPACITY     = 16;
    localparam int DEF_PAYLOAD_BITS = 32;

    localparam int KEY_BITS   = 32;
    localparam int COUNT_BITS = 5;

    typedef logic signed [KEY_BITS-1:0] t_key;

    // Command codes; 5 to 7 are unused and answer done with the count unchanged.
    typedef enum logic [2:0] {
        CMD_APPEND     = 3'd0,
        CMD_SORTED     = 3'd1,
        CMD_REMOVE_END = 3'd2,
        CMD_REMOVE_KEY = 3'd3,
        CMD_CLEAR      = 3'd4
    } t_cmd;

    typedef enum logic [1:0] {
        ST_DONE      = 2'd0,
        ST_FULL      = 2'd1,
        ST_EMPTY     = 2'd2,
        ST_NOT_FOUND = 2'd3
    } t_status;

    // What every cell does.
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_APPEND = 2'd1,
        CELL_SORTED = 2'd2,
        CELL_REMOVE = 2'd3
    } t_cell_op;

    typedef struct packed {
        t_cell_op op;
        t_key     key;
    } t_cell_ctl;

    typedef struct packed {
        logic [2:0]           cmd;
        t_key                 key;
        logic [31:0]          payload;
    } t_in_beat;

    typedef struct packed {
        logic [1:0]            status;
        logic [COUNT_BITS-1:0] count;
    } t_out_beat;

endpackage

`default_nettype wire

// ===== hdl/skl_cell.sv =====
`default_nettype none

module skl_cell import skl_pkg::*; #(
    parameter int PAYLOAD_BITS = DEF_PAYLOAD_BITS
) (
    input  wire logic                    i_clk,
    input  wire t_cell_ctl               i_ctl,
    input  wire logic [PAYLOAD_BITS-1:0] i_new_payload,
    input  wire logic                    i_occ,
    input  wire logic                    i_hit,
    input  wire t_key                    i_left_key,
    input  wire logic [PAYLOAD_BITS-1:0] i_left_payload,
    input  wire t_key                    i_right_key,
    input  wire logic [PAYLOAD_BITS-1:0] i_right_payload,
    output t_key                         o_key,
    output logic [PAYLOAD_BITS-1:0]      o_payload,
    output logic                         o_hit
);

    t_key                    r_key;
    logic [PAYLOAD_BITS-1:0] r_payload;
    t_key                    n_key;
    logic [PAYLOAD_BITS-1:0] n_payload;
    logic                    match;
    logic                    hit_self;

    always_comb begin
        unique case (i_ctl.op)
            CELL_SORTED: match = !($signed(r_key) < $signed(i_ctl.key));
            CELL_REMOVE: match = (r_key == i_ctl.key);
            CELL_APPEND: match = 1'b0;
            CELL_HOLD:   match = 1'b0;
            default:     match = 1'b0;
        endcase
    end

    assign hit_self = i_occ & match;
    assign o_hit    = i_hit | hit_self;

    // Shift toward the tail behind the insert point, toward the head behind a removal.
    always_comb begin
        n_key     = r_key;
        n_payload = r_payload;
        unique case (i_ctl.op)
            CELL_APPEND, CELL_SORTED: begin
                if (i_hit) begin
                    n_key     = i_left_key;
                    n_payload = i_left_payload;
                end else if (hit_self || !i_occ) begin
                    n_key     = i_ctl.key;
                    n_payload = i_new_payload;
                end
            end
            CELL_REMOVE: begin
                if (i_hit || hit_self) begin
                    n_key     = i_right_key;
                    n_payload = i_right_payload;
                end
            end
            CELL_HOLD: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_key     <= n_key;
        r_payload <= n_payload;
    end

    assign o_key     = r_key;
    assign o_payload = r_payload;

endmodule

`default_nettype wire

// ===== hdl/sorted_key_list_top.sv =====
// The result beat of a command is registered at the clock edge that accepts the command.
// Throughput: one command per cycle while results are taken; every command finishes
//   in a single pass of the cell row, whose match flag ripples from head to tail.
// Reset: i_rst_n low at a rising edge empties the list and drops any pending result.
//   No clearing pass is needed; what cells at or beyond the count hold never counts.
`default_nettype none

module sorted_key_list_top import skl_pkg::*; #(
    parameter int CAPACITY     = DEF_CAPACITY,
    parameter int PAYLOAD_BITS = DEF_PAYLOAD_BITS
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_beat  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_beat      o_out_data
);

    // Count must reach CAPACITY itself.
    localparam int CW = $clog2(CAPACITY + 1);

    logic [CW-1:0]           r_count;
    logic [CW-1:0]           n_count;
    logic                    r_out_valid;
    t_out_beat               r_out_data;
    t_out_beat               n_out_data;

    logic                    accept;
    logic                    full;
    logic                    empty;
    t_cell_ctl               ctl;
    logic [PAYLOAD_BITS-1:0] new_payload;
    logic [PAYLOAD_BITS+31:0] payload_wide;
    logic [CW+COUNT_BITS-1:0] count_wide;

    t_key                    cell_key     [CAPACITY];
    logic [PAYLOAD_BITS-1:0] cell_payload [CAPACITY];
    logic                    hit          [CAPACITY+1];
    logic                    occ          [CAPACITY];

    // The output register parts the two sides; stall upstream only when it is full and held.
    assign o_in_stall = r_out_valid & i_out_stall;
    assign accept     = i_in_valid & ~o_in_stall;

    assign full  = (r_count == CW'(CAPACITY));
    assign empty = (r_count == '0);

    // Keep the low PAYLOAD_BITS bits of the incoming word, zero above 32.
    assign payload_wide = {{PAYLOAD_BITS{1'b0}}, i_in_data.payload};
    assign new_payload  = payload_wide[PAYLOAD_BITS-1:0];

    // Broadcast the operation to every cell; hold for clear, end removal, a full append or an empty removal.
    always_comb begin
        ctl.key = i_in_data.key;
        ctl.op  = CELL_HOLD;
        if (accept) begin
            unique case (i_in_data.cmd)
                CMD_APPEND:     ctl.op = full  ? CELL_HOLD : CELL_APPEND;
                CMD_SORTED:     ctl.op = full  ? CELL_HOLD : CELL_SORTED;
                CMD_REMOVE_KEY: ctl.op = empty ? CELL_HOLD : CELL_REMOVE;
                CMD_REMOVE_END: ctl.op = CELL_HOLD;
                CMD_CLEAR:      ctl.op = CELL_HOLD;
                default:        ctl.op = CELL_HOLD;
            endcase
        end
    end

    // Row of cells: slot 0 is the head. The hit flag says a match sits nearer the head.
    assign hit[0] = 1'b0;

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        t_key                    left_key;
        logic [PAYLOAD_BITS-1:0] left_payload;
        t_key                    right_key;
        logic [PAYLOAD_BITS-1:0] right_payload;

        assign occ[g] = (CW'(g) < r_count);

        if (g == 0) begin : g_head
            // Never selected: nothing lies ahead of the head.
            assign left_key     = ctl.key;
            assign left_payload = new_payload;
        end else begin : g_mid
            assign left_key     = cell_key[g-1];
            assign left_payload = cell_payload[g-1];
        end

        if (g == CAPACITY - 1) begin : g_tail
            // The tail slot leaves the list on a removal; its content no longer counts.
            assign right_key     = cell_key[g];
            assign right_payload = cell_payload[g];
        end else begin : g_inner
            assign right_key     = cell_key[g+1];
            assign right_payload = cell_payload[g+1];
        end

        skl_cell #(
            .PAYLOAD_BITS (PAYLOAD_BITS)
        ) u_cell (
            .i_clk           (i_clk),
            .i_ctl           (ctl),
            .i_new_payload   (new_payload),
            .i_occ           (occ[g]),
            .i_hit           (hit[g]),
            .i_left_key      (left_key),
            .i_left_payload  (left_payload),
            .i_right_key     (right_key),
            .i_right_payload (right_payload),
            .o_key           (cell_key[g]),
            .o_payload       (cell_payload[g]),
            .o_hit           (hit[g+1])
        );
    end

    // Count update and status for the result beat.
    always_comb begin
        n_count           = r_count;
        n_out_data.status = ST_DONE;
        unique case (i_in_data.cmd)
            CMD_APPEND, CMD_SORTED: begin
                if (full) begin
                    n_out_data.status = ST_FULL;
                end else begin
                    n_count = r_count + CW'(1);
                end
            end
            CMD_REMOVE_END: begin
                if (empty) begin
                    n_out_data.status = ST_EMPTY;
                end else begin
                    n_count = r_count - CW'(1);
                end
            end
            CMD_REMOVE_KEY: begin
                if (empty) begin
                    n_out_data.status = ST_EMPTY;
                end else if (hit[CAPACITY]) begin
                    n_count = r_count - CW'(1);
                end else begin
                    n_out_data.status = ST_NOT_FOUND;
                end
            end
            CMD_CLEAR: begin
                n_count = '0;
            end
            default: begin
            end
        endcase
        // Report the count modulo 32.
        count_wide       = {{COUNT_BITS{1'b0}}, n_count};
        n_out_data.count = count_wide[COUNT_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Hold the result while it is stalled; load a new one with each accepted beat.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

`default_nettype wire

// ===== hdl/skl_checker.sv =====
`default_nettype none

module skl_checker import skl_pkg::*; #(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      o_in_stall,
    input wire t_in_beat  i_in_data,
    input wire logic      o_out_valid,
    input wire logic      i_out_stall,
    input wire t_out_beat o_out_data
);

    logic in_acc;

    assign in_acc = i_in_valid & ~o_in_stall;

    a_reset_drops_result: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result beat pending after reset");

    a_stalled_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result beat changed");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && i_in_data.cmd == CMD_CLEAR |=>
            o_out_valid && o_out_data.count == '0 && o_out_data.status == ST_DONE)
        else $error("clear did not answer done with an empty list");

    a_full_at_capacity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_data.status == ST_FULL |->
            o_out_data.count == COUNT_BITS'(CAPACITY))
        else $error("full status with count below capacity");

    a_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && CAPACITY < 32 |-> int'(o_out_data.count) <= CAPACITY)
        else $error("count above capacity");

endmodule

bind sorted_key_list_top skl_checker #(.CAPACITY(CAPACITY)) u_skl_checker (.*);

`default_nettype wire
